@@ src/mlbp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the multi-block lbp core
// no dependencies

package mlbp_pkg;

  localparam int CRD_W = 12;  // signed rectangle coordinate width
  localparam int DIM_W = 9;   // rectangle side width (2x scale reaches 510)

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_MULTI  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  // clockwise cell order from top-left: column and row of each outer cell
  localparam logic [1:0] ORD_I [8] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};
  localparam logic [1:0] ORD_J [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1};

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic [DIM_W-1:0]        w;
    logic [DIM_W-1:0]        h;
  } rect_t;

  // one queued job: a pixel load or up to three rectangles
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] pixel;
    rect_t      r0;
    rect_t      r1;
    rect_t      r2;
  } job_t;

  // floor(v / 3) for an 8-bit value by reciprocal multiply
  function automatic logic [7:0] div3(input logic [7:0] v);
    logic [15:0] m;
    m = 16'(v) * 16'd171;
    return {1'b0, m[15:9]};
  endfunction

endpackage

@@ src/multiblock_lbp_integral_core.sv @@
`timescale 1ns / 1ps
// pixel load: through S_LOAD and back to idle before the next item is taken; no result
// query: per rectangle inside the image, setup, area, reads of the 16 grid corners, cell
// sums, then 8 multiply/compare pairs; one outside goes from setup to next; plus a take and
// a post state; mode 1 does one rectangle, mode 2 three; a 4-entry queue buffers items
// sync reset clears queue, load position, result; width/height to 128; store not cleared
// depends on mlbp_pkg, mlbp_front, mlbp_fifo, mlbp_back

module multiblock_lbp_integral_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  logic [7:0]        pixel,
  input  logic signed [7:0] rect_x,
  input  logic signed [7:0] rect_y,
  input  logic [7:0]        rect_w,
  input  logic [7:0]        rect_h,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        code_base,
  output logic [7:0]        code_mid,
  output logic [7:0]        code_wide
);
  import mlbp_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, head_job;

  assign cfg_ready = 1'b1;

  mlbp_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .pixel    (pixel),
    .rect_x   (rect_x),
    .rect_y   (rect_y),
    .rect_w   (rect_w),
    .rect_h   (rect_h),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  mlbp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_job)
  );

  mlbp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_base (code_base),
    .code_mid  (code_mid),
    .code_wide (code_wide)
  );

endmodule

@@ src/mlbp_front.sv @@
`timescale 1ns / 1ps
// front end: accepts items, drops unused modes, derives scaled rectangles
// depends on mlbp_pkg

module mlbp_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic [7:0]          pixel,
  input  logic signed [7:0]   rect_x,
  input  logic signed [7:0]   rect_y,
  input  logic [7:0]          rect_w,
  input  logic [7:0]          rect_h,
  input  logic                q_full,
  output logic                q_push,
  output mlbp_pkg::job_t      q_job
);
  import mlbp_pkg::*;

  logic [7:0] wq, hq, wa, ha, d, e;
  logic [1:0] wr, hr;
  logic signed [CRD_W-1:0] x0, y0;

  function automatic logic [7:0] grow(input logic [7:0] v);
    if (v[0]) return {1'b0, v[7:1]};
    if (v == 8'd0) return 8'd2;
    return {1'b0, v[7:1]} + 8'd1;
  endfunction

  always_comb begin
    x0 = CRD_W'(rect_x);
    y0 = CRD_W'(rect_y);
    wq = div3(rect_w);
    hq = div3(rect_h);
    wr = 2'(rect_w - 8'(wq * 8'd3));
    hr = 2'(rect_h - 8'(hq * 8'd3));
    // size adjust to a multiple of three
    unique case (wr)
      2'd1:    wa = rect_w - 8'd1;
      2'd2:    wa = rect_w + 8'd1;
      default: wa = rect_w;
    endcase
    unique case (hr)
      2'd1:    ha = rect_h - 8'd1;
      2'd2:    ha = rect_h + 8'd1;
      default: ha = rect_h;
    endcase
    d = grow(wa);
    e = grow(ha);

    q_job.mode  = mode;
    q_job.pixel = pixel;
    q_job.r0.x  = x0;
    q_job.r0.y  = y0;
    q_job.r0.w  = DIM_W'(rect_w);
    q_job.r0.h  = DIM_W'(rect_h);
    q_job.r1.x  = x0 - CRD_W'(d[7:1]) - CRD_W'(1);
    q_job.r1.y  = y0 - CRD_W'(e[7:1]) - CRD_W'(1);
    q_job.r1.w  = DIM_W'(wa) + DIM_W'(d);
    q_job.r1.h  = DIM_W'(ha) + DIM_W'(e);
    q_job.r2.x  = x0 - CRD_W'(d);
    q_job.r2.y  = y0 - CRD_W'(e);
    q_job.r2.w  = {wa, 1'b0};
    q_job.r2.h  = {ha, 1'b0};
    if (mode == MODE_MULTI) begin
      q_job.r0.w = DIM_W'(wa);
      q_job.r0.h = DIM_W'(ha);
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (mode != MODE_NONE);

endmodule

@@ src/mlbp_fifo.sv @@
`timescale 1ns / 1ps
// short job queue between front end and back end
// depends on mlbp_pkg

module mlbp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mlbp_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output mlbp_pkg::job_t  head
);
  import mlbp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full      = (count == (PW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop) count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

endmodule

@@ src/mlbp_back.sv @@
`timescale 1ns / 1ps
// back end: integral image store, pixel loader and rectangle code engine
// depends on mlbp_pkg

module mlbp_back #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            q_valid,
  input  mlbp_pkg::job_t  q_job,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      code_base,
  output logic [7:0]      code_mid,
  output logic [7:0]      code_wide
);
  import mlbp_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int SW  = $clog2(MAX_WIDTH * MAX_HEIGHT * 255 + 1);
  localparam int RSW = $clog2(MAX_WIDTH * 255 + 1);
  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int RB  = $clog2(MAX_HEIGHT);
  localparam int PW  = SW + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SETUP, S_AREA, S_READ, S_SUMS, S_MUL, S_CMP, S_NEXT, S_DONE
  } state_t;

  state_t state;

  logic [SW-1:0] mem [MAX_WIDTH * MAX_HEIGHT];
  logic [SW-1:0] mem_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [SW-1:0] wr_data;
  logic          wr_en;

  logic [7:0]     img_w, img_h, effw, effh;
  logic [CB-1:0]  load_col;
  logic [RB-1:0]  load_row;
  logic [RSW-1:0] row_sum;
  logic [AW-1:0]  load_idx;

  job_t                    cur;
  logic [1:0]              ri;
  rect_t                   rc;
  logic signed [CRD_W-1:0] rb [4];
  logic signed [CRD_W-1:0] cb [4];
  logic [7:0]              cw, ch, mw, mh;
  logic [15:0]             a_cc, a_mc, a_cm, a_mm;
  logic [4:0]              k;
  logic                    pend_neg;
  logic [SW-1:0]           g [16];
  logic [SW-1:0]           csum [9];
  logic [2:0]              b;
  logic [PW-1:0]           p1, p2;
  logic                    nz;
  logic [7:0]              code;
  logic [7:0]              codes [3];

  // rectangle setup terms
  logic                    r_ok;
  logic [7:0]              w8, h8, cw_n, ch_n;
  logic signed [CRD_W:0]   x_end, y_end;
  logic signed [CRD_W-1:0] gr, gc;
  logic                    g_neg;
  logic [1:0]              oi, oj;
  logic [15:0]             a_sel;

  always_comb begin
    effw = img_w;
    if (img_w == 8'd0) effw = 8'd1;
    else if (int'(img_w) > MAX_WIDTH) effw = 8'(MAX_WIDTH);
    effh = img_h;
    if (img_h == 8'd0) effh = 8'd1;
    else if (int'(img_h) > MAX_HEIGHT) effh = 8'(MAX_HEIGHT);
  end

  assign load_idx = AW'(load_row) * AW'(MAX_WIDTH) + AW'(load_col);

  always_comb begin
    unique case (ri)
      2'd1:    rc = cur.r1;
      2'd2:    rc = cur.r2;
      default: rc = cur.r0;
    endcase
    x_end = (CRD_W+1)'(rc.x) + $signed((CRD_W+1)'(rc.w));
    y_end = (CRD_W+1)'(rc.y) + $signed((CRD_W+1)'(rc.h));
    r_ok  = (rc.w != '0) && (rc.h != '0) && !rc.x[CRD_W-1] && !rc.y[CRD_W-1] &&
            (x_end <= $signed((CRD_W+1)'(effw))) && (y_end <= $signed((CRD_W+1)'(effh)));
    w8    = rc.w[7:0];
    h8    = rc.h[7:0];
    cw_n  = div3(w8);
    ch_n  = div3(h8);
  end

  // grid corner for the current read step; a corner above or left of the image is zero
  always_comb begin
    gr    = rb[k[3:2]];
    gc    = cb[k[1:0]];
    g_neg = gr[CRD_W-1] || gc[CRD_W-1];
    if (state == S_READ) begin
      rd_addr = AW'(gr[RB-1:0]) * AW'(MAX_WIDTH) + AW'(gc[CB-1:0]);
    end else begin
      rd_addr = load_idx - AW'(MAX_WIDTH);
    end
  end

  always_comb begin
    oi = ORD_I[b];
    oj = ORD_J[b];
    if (oi == 2'd1) a_sel = a_mc;
    else if (oj == 2'd1) a_sel = a_cm;
    else a_sel = a_cc;
  end

  always_comb begin
    wr_en   = (state == S_LOAD);
    wr_addr = load_idx;
    wr_data = SW'(row_sum) + SW'(cur.pixel) + ((load_row != '0) ? mem_q : '0);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      img_w     <= 8'd128;
      img_h     <= 8'd128;
      load_col  <= '0;
      load_row  <= '0;
      row_sum   <= '0;
      ri        <= '0;
      k         <= '0;
      b         <= '0;
    end else begin
      // a new result in S_DONE takes over the slot itself
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_job;
            ri  <= '0;
            state <= (q_job.mode == MODE_LOAD) ? S_LOAD : S_SETUP;
          end
        end
        S_LOAD: begin
          if (int'(load_col) + 1 >= int'(effw)) begin
            load_col <= '0;
            row_sum  <= '0;
            if (int'(load_row) + 1 >= int'(effh)) load_row <= '0;
            else load_row <= load_row + RB'(1);
          end else begin
            load_col <= load_col + CB'(1);
            row_sum  <= row_sum + RSW'(cur.pixel);
          end
          state <= S_IDLE;
        end
        S_SETUP: begin
          cw <= cw_n;
          ch <= ch_n;
          mw <= w8 - {cw_n[6:0], 1'b0};
          mh <= h8 - {ch_n[6:0], 1'b0};
          rb[0] <= rc.y - CRD_W'(1);
          rb[1] <= rc.y + CRD_W'(ch_n) - CRD_W'(1);
          rb[2] <= rc.y + CRD_W'(rc.h) - CRD_W'(ch_n) - CRD_W'(1);
          rb[3] <= rc.y + CRD_W'(rc.h) - CRD_W'(1);
          cb[0] <= rc.x - CRD_W'(1);
          cb[1] <= rc.x + CRD_W'(cw_n) - CRD_W'(1);
          cb[2] <= rc.x + CRD_W'(rc.w) - CRD_W'(cw_n) - CRD_W'(1);
          cb[3] <= rc.x + CRD_W'(rc.w) - CRD_W'(1);
          code  <= '0;
          state <= r_ok ? S_AREA : S_NEXT;
        end
        S_AREA: begin
          a_cc  <= 16'(cw) * 16'(ch);
          a_mc  <= 16'(mw) * 16'(ch);
          a_cm  <= 16'(cw) * 16'(mh);
          a_mm  <= 16'(mw) * 16'(mh);
          k     <= '0;
          state <= S_READ;
        end
        S_READ: begin
          // read data is registered and arrives in the step after its address
          if (k != '0) g[4'(k - 5'd1)] <= pend_neg ? '0 : mem_q;
          pend_neg <= g_neg;
          k <= k + 5'd1;
          if (k == 5'd16) state <= S_SUMS;
        end
        S_SUMS: begin
          for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
              csum[j*3+i] <= g[(j+1)*4+i+1] - g[j*4+i+1] - g[(j+1)*4+i] + g[j*4+i];
            end
          end
          b     <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          p1    <= PW'(csum[4'(oj) * 4'd3 + 4'(oi)]) * PW'(a_mm);
          p2    <= PW'(csum[4]) * PW'(a_sel);
          nz    <= (a_sel != 16'd0);
          state <= S_CMP;
        end
        S_CMP: begin
          code <= {code[6:0], nz && (p1 >= p2)};
          b    <= b + 3'd1;
          state <= (b == 3'd7) ? S_NEXT : S_MUL;
        end
        S_NEXT: begin
          codes[ri] <= code;
          if (cur.mode == MODE_SINGLE || ri == 2'd2) begin
            state <= S_DONE;
          end else begin
            ri    <= ri + 2'd1;
            state <= S_SETUP;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            code_base <= codes[0];
            code_mid  <= (cur.mode == MODE_SINGLE) ? 8'd0 : codes[1];
            code_wide <= (cur.mode == MODE_SINGLE) ? 8'd0 : codes[2];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // register writes restart the image load
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            img_w    <= cfg_data;
            load_col <= '0;
            load_row <= '0;
            row_sum  <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            img_h    <= cfg_data;
            load_col <= '0;
            load_row <= '0;
            row_sum  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ src/mlbp_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the multi-block lbp core, bound to the top level
// depends on multiblock_lbp_integral_core

module mlbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] code_base,
  input logic [7:0] code_mid,
  input logic [7:0] code_wide
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(code_base) && $stable(code_mid) && $stable(code_wide))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write refused");

endmodule

bind multiblock_lbp_integral_core mlbp_checker u_mlbp_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .code_base (code_base),
  .code_mid  (code_mid),
  .code_wide (code_wide)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for multiblock_lbp_integral_core: image loads and lbp queries
// depends on mlbp_pkg and the core rtl; keeps its own integral-image predictor

module tb;
  import mlbp_pkg::*;

  typedef struct {
    logic [1:0]        mode;
    logic [7:0]        pixel;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic [7:0]        w;
    logic [7:0]        h;
  } item_t;

  typedef struct {
    logic [7:0] base;
    logic [7:0] mid;
    logic [7:0] wide;
  } codes_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [7:0] cfg_data = 8'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_NONE;
  logic [7:0] pixel = 8'd0;
  logic signed [7:0] rect_x = 8'sd0;
  logic signed [7:0] rect_y = 8'sd0;
  logic [7:0] rect_w = 8'd0;
  logic [7:0] rect_h = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] code_base, code_mid, code_wide;

  multiblock_lbp_integral_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .pixel(pixel),
    .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
    .out_valid(out_valid), .out_stall(out_stall),
    .code_base(code_base), .code_mid(code_mid), .code_wide(code_wide)
  );

  always #1 clk = ~clk;

  item_t  pending_items[$];
  codes_t expected_codes[$];
  int     fail_count = 0;
  bit     calm = 1'b0;
  bit     hold_req = 1'b0;

  // predictor state
  int unsigned isum[128 * 128];
  int unsigned load_c, load_r, row_acc;
  int unsigned img_w, img_h;

  function automatic int eff_w();
    if (img_w == 0) return 1;
    return (img_w > 128) ? 128 : img_w;
  endfunction

  function automatic int eff_h();
    if (img_h == 0) return 1;
    return (img_h > 128) ? 128 : img_h;
  endfunction

  function automatic longint corner(int r, int c);
    if (r < 0 || c < 0 || r >= 128 || c >= 128) return 0;
    return isum[r * 128 + c];
  endfunction

  function automatic longint cell_sum(int x, int y, int w, int h);
    if (w <= 0 || h <= 0) return 0;
    return corner(y + h - 1, x + w - 1) - corner(y - 1, x + w - 1)
         - corner(y + h - 1, x - 1) + corner(y - 1, x - 1);
  endfunction

  function automatic logic [7:0] lbp_code(int x, int y, int w, int h);
    int cw, ch, mw, mh;
    int xs[3], ys[3], ws[3], hs[3];
    int ci[8] = '{0, 1, 2, 2, 2, 1, 0, 0};
    int cj[8] = '{0, 0, 0, 1, 2, 2, 2, 1};
    longint sc, ac, s, a;
    logic [7:0] code;
    code = 8'd0;
    if (w <= 0 || h <= 0 || x < 0 || y < 0 || x + w > eff_w() || y + h > eff_h())
      return 8'd0;
    cw = w / 3; ch = h / 3;
    mw = w - 2 * cw; mh = h - 2 * ch;
    xs = '{x, x + cw, x + cw + mw};
    ys = '{y, y + ch, y + ch + mh};
    ws = '{cw, mw, cw};
    hs = '{ch, mh, ch};
    sc = cell_sum(xs[1], ys[1], mw, mh);
    ac = longint'(mw) * mh;
    for (int k = 0; k < 8; k++) begin
      logic b;
      b = 1'b0;
      if (ws[ci[k]] > 0 && hs[cj[k]] > 0) begin
        s = cell_sum(xs[ci[k]], ys[cj[k]], ws[ci[k]], hs[cj[k]]);
        a = longint'(ws[ci[k]]) * hs[cj[k]];
        b = (s * ac >= sc * a);
      end
      code = {code[6:0], b};
    end
    return code;
  endfunction

  function automatic int grow(int v);
    if (v % 2) return v / 2;
    return (v == 0) ? 2 : v / 2 + 1;
  endfunction

  // advances the integral image or queues the codes an accepted item yields
  task automatic predict_item(item_t it);
    int x, y, w, h, d, e, idx;
    int unsigned above;
    codes_t c;
    x = it.x; y = it.y; w = it.w; h = it.h;
    above = 0;
    if (it.mode == MODE_LOAD) begin
      idx = load_r * 128 + load_c;
      row_acc += it.pixel;
      if (load_r > 0) above = isum[idx - 128];
      isum[idx] = row_acc + above;
      load_c++;
      if (load_c >= eff_w()) begin
        load_c = 0;
        row_acc = 0;
        load_r++;
        if (load_r >= eff_h()) load_r = 0;
      end
    end else if (it.mode == MODE_SINGLE) begin
      c.base = lbp_code(x, y, w, h);
      c.mid = 8'd0;
      c.wide = 8'd0;
      expected_codes.push_back(c);
    end else if (it.mode == MODE_MULTI) begin
      if (w % 3 == 1) w--; else if (w % 3 == 2) w++;
      if (h % 3 == 1) h--; else if (h % 3 == 2) h++;
      d = grow(w);
      e = grow(h);
      c.base = lbp_code(x, y, w, h);
      c.mid = lbp_code(x - d / 2 - 1, y - e / 2 - 1, w + d, h + e);
      c.wide = lbp_code(x - d, y - e, 2 * w, 2 * h);
      expected_codes.push_back(c);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int gap_left = 0;
  always @(posedge clk) begin
    item_t it;
    bit free;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      free = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        it.mode = mode; it.pixel = pixel; it.x = rect_x; it.y = rect_y;
        it.w = rect_w; it.h = rect_h;
        predict_item(it);
      end
      if (free) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          mode <= it.mode; pixel <= it.pixel; rect_x <= it.x; rect_y <= it.y;
          rect_w <= it.w; rect_h <= it.h;
          in_valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall, with one long hold-off while the sender keeps going
  int stall_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      stall_left <= 600;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  // monitor
  int mismatches = 0;
  always @(posedge clk) begin
    codes_t c;
    if (!rst && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        fail_count++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h %h %h", code_base, code_mid, code_wide);
      end else begin
        c = expected_codes.pop_front();
        if (c.base !== code_base || c.mid !== code_mid || c.wide !== code_wide) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10)
            $display("code mismatch: expected %h %h %h, got %h %h %h",
                     c.base, c.mid, c.wide, code_base, code_mid, code_wide);
        end
      end
    end
  end

  task automatic push_item(logic [1:0] m, logic [7:0] p, int x, int y, int w, int h);
    item_t it;
    it.mode = m; it.pixel = p; it.x = x[7:0]; it.y = y[7:0]; it.w = w[7:0]; it.h = h[7:0];
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_codes.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) img_w = val; else img_h = val;
    load_c = 0; load_r = 0; row_acc = 0;
  endtask

  // fill: 0 random, 1 all full scale, 2 all zero
  task automatic load_image(int fill);
    int n;
    logic [7:0] p;
    n = eff_w() * eff_h();
    for (int i = 0; i < n; i++) begin
      p = (fill == 1) ? 8'hff : (fill == 2) ? 8'h00 : 8'($urandom);
      push_item(MODE_LOAD, p, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic random_queries(int n);
    int w, h, x, y, r;
    logic [1:0] m;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      m = ($urandom_range(0, 1) == 0) ? MODE_SINGLE : MODE_MULTI;
      if (r < 80) begin
        w = $urandom_range(0, eff_w());
        h = $urandom_range(0, eff_h());
        if (m == MODE_MULTI && r < 50) begin
          w = w / 2;
          h = h / 2;
        end
        x = $urandom_range(0, eff_w() - w);
        y = $urandom_range(0, eff_h() - h);
        if (m == MODE_MULTI && r < 50) begin
          x = $urandom_range(w / 2 + 2, eff_w() - w) > eff_w() ? 0 : x + w / 2;
          y = y + h / 2;
        end
        push_item(m, 8'($urandom), x, y, w, h);
      end else if (r < 95) begin
        push_item(m, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
      end else begin
        // ignored mode mixed in with the queries
        push_item(MODE_NONE, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic set_image(logic [7:0] w, logic [7:0] h);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  initial begin
    load_c = 0; load_r = 0; row_acc = 0;
    img_w = 128; img_h = 128;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: small image, edge rectangles, zero-area cells, every mode
    set_image(8'd12, 8'd9);
    load_image(0);
    push_item(MODE_SINGLE, 8'h00, 0, 0, 12, 9);
    push_item(MODE_SINGLE, 8'hff, 0, 0, 0, 9);
    push_item(MODE_SINGLE, 8'h00, 0, 0, 12, 0);
    push_item(MODE_SINGLE, 8'h00, 0, 0, 2, 2);
    push_item(MODE_SINGLE, 8'h00, 3, 2, 5, 4);
    push_item(MODE_SINGLE, 8'h00, -1, 0, 3, 3);
    push_item(MODE_SINGLE, 8'h00, 10, 0, 3, 3);
    push_item(MODE_SINGLE, 8'h00, 0, 7, 3, 3);
    push_item(MODE_SINGLE, 8'h00, -128, -128, 255, 255);
    push_item(MODE_SINGLE, 8'h00, 127, 127, 128, 128);
    push_item(MODE_SINGLE, 8'h00, 11, 8, 1, 1);
    push_item(MODE_NONE, 8'hff, -1, -1, 255, 255);
    push_item(MODE_MULTI, 8'h00, 3, 3, 3, 3);
    push_item(MODE_MULTI, 8'h00, 4, 3, 4, 5);
    push_item(MODE_MULTI, 8'h00, 0, 0, 12, 9);
    push_item(MODE_MULTI, 8'h00, 5, 4, 0, 0);
    push_item(MODE_MULTI, 8'h00, -128, 127, 255, 128);
    random_queries(10);

    set_image(8'd128, 8'd1);
    load_image(0);
    random_queries(20);

    // out-of-range register values
    set_image(8'd0, 8'd0);
    load_image(0);
    random_queries(10);

    set_image(8'd1, 8'd128);
    load_image(0);
    random_queries(20);

    set_image(8'd255, 8'd1);
    load_image(1);
    random_queries(20);

    calm = 1'b1;
    set_image(8'd10, 8'd8);
    load_image(2);
    random_queries(20);

    // second load wraps over the first image
    set_image(8'd6, 8'd5);
    calm = 1'b0;
    load_image(0);
    load_image(0);
    random_queries(40);

    set_image(8'd12, 8'd8);
    load_image(0);
    wait_idle();
    hold_req = 1'b1;
    random_queries(60);

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule
